// ===== src/tss_pkg.sv =====
// ----------------------------------------------------------------------------
// tss_pkg
// shared types and codes for the tombstone slot table
// ----------------------------------------------------------------------------
package tss_pkg;

    typedef enum logic [1:0] {
        CMD_INSERT = 2'd0,
        CMD_DELETE = 2'd1,
        CMD_LIST   = 2'd2
    } t_cmd;

    typedef enum logic [2:0] {
        ST_STORED     = 3'd0,
        ST_REVIVED    = 3'd1,
        ST_FULL_DROP  = 3'd2,
        ST_DELETED    = 3'd3,
        ST_LIST_ENTRY = 3'd4,
        ST_LIST_EMPTY = 3'd5
    } t_status;

    typedef struct packed {
        logic [1:0]         cmd;
        logic signed [31:0] item_value;
    } t_in_item;

    typedef struct packed {
        logic [2:0]         status;
        logic [3:0]         slot_index;
        logic signed [31:0] out_value;
        logic [4:0]         match_count;
        logic               last;
    } t_out_item;

    typedef struct packed {
        t_cmd               cmd;
        logic signed [31:0] value;
    } t_job;

endpackage

// ===== src/tss_front.sv =====
// ----------------------------------------------------------------------------
// tss_front
// accepts input beats, drops unused commands, queues jobs for the back end
// ----------------------------------------------------------------------------
module tss_front
    import tss_pkg::*;
(
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  logic     push,
    output logic     full,
    input  t_in_item i_item,
    output logic     o_job_valid,
    output t_job     o_job,
    input  logic     i_job_pop
);

    t_job       r_q [2];
    logic       r_wr_ptr;
    logic       r_rd_ptr;
    logic [1:0] r_count;
    logic       w_is_op;
    logic       w_enq;
    logic       w_deq;

    always_comb begin
        unique case (i_item.cmd)
            CMD_INSERT, CMD_DELETE, CMD_LIST: w_is_op = 1'b1;
            default:                          w_is_op = 1'b0;
        endcase
    end

    assign full        = (r_count == 2'd2);
    assign w_enq       = push && !full && w_is_op;
    assign w_deq       = i_job_pop && (r_count != 2'd0);
    assign o_job_valid = (r_count != 2'd0);
    assign o_job       = r_q[r_rd_ptr];

    always_ff @(posedge i_clk) begin
        if (w_enq) begin
            r_q[r_wr_ptr] <= '{cmd: t_cmd'(i_item.cmd), value: i_item.item_value};
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= 1'b0;
            r_rd_ptr <= 1'b0;
            r_count  <= 2'd0;
        end else begin
            if (w_enq) begin
                r_wr_ptr <= !r_wr_ptr;
            end
            if (w_deq) begin
                r_rd_ptr <= !r_rd_ptr;
            end
            unique case ({w_enq, w_deq})
                2'b10:   r_count <= r_count + 2'd1;
                2'b01:   r_count <= r_count - 2'd1;
                default: r_count <= r_count;
            endcase
        end
    end

endmodule

// ===== src/tss_back.sv =====
// ----------------------------------------------------------------------------
// tss_back
// slot table engine: parallel match, then insert/delete update or list walk
// ----------------------------------------------------------------------------
module tss_back
    import tss_pkg::*;
#(
    parameter int TABLE_DEPTH = 16,
    parameter int VALUE_WIDTH = 32
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_job_valid,
    input  t_job      i_job,
    output logic      o_job_pop,
    output logic      empty,
    input  logic      pop,
    output t_out_item o_result
);

    localparam int IW = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
    localparam int CW = $clog2(TABLE_DEPTH + 1);

    typedef enum logic [1:0] {
        S_IDLE,
        S_EXEC,
        S_LIST
    } t_state;

    t_state                   r_state;
    t_cmd                     r_cmd;
    logic [VALUE_WIDTH-1:0]   r_val;
    logic [VALUE_WIDTH-1:0]   r_vals [TABLE_DEPTH];
    logic [TABLE_DEPTH-1:0]   r_valid;
    logic [CW-1:0]            r_used;
    logic [TABLE_DEPTH-1:0]   r_rev_vec;
    logic [TABLE_DEPTH-1:0]   r_free_vec;
    logic [TABLE_DEPTH-1:0]   r_del_vec;
    logic                     r_any;
    logic [IW-1:0]            r_last;
    logic [IW-1:0]            r_cursor;
    t_out_item                r_out;
    logic                     r_out_valid;

    logic                     w_out_ready;
    logic                     w_emit;
    logic [63:0]              w_in_wide;
    logic [VALUE_WIDTH-1:0]   w_in_val;
    logic [63:0]              w_val_wide;
    logic [63:0]              w_cur_wide;
    logic [TABLE_DEPTH-1:0]   w_eq;
    logic [TABLE_DEPTH-1:0]   w_below_used;
    logic [IW-1:0]            w_ins_idx;
    logic [CW-1:0]            w_ins_used;
    t_status                  w_ins_status;
    logic                     w_ins_write;
    logic                     w_ins_set;
    logic [CW-1:0]            w_del_cnt;
    logic [IW+3:0]            w_ins_idx_x;
    logic [IW+3:0]            w_cur_idx_x;
    logic [CW+4:0]            w_del_cnt_x;
    logic                     w_mem_we;

    function automatic logic [IW-1:0] first_set(input logic [TABLE_DEPTH-1:0] vec);
        logic [IW-1:0] idx;
        idx = '0;
        for (int i = TABLE_DEPTH - 1; i >= 0; i--) begin
            if (vec[i]) begin
                idx = IW'(i);
            end
        end
        return idx;
    endfunction

    function automatic logic [IW-1:0] last_set(input logic [TABLE_DEPTH-1:0] vec);
        logic [IW-1:0] idx;
        idx = '0;
        for (int i = 0; i < TABLE_DEPTH; i++) begin
            if (vec[i]) begin
                idx = IW'(i);
            end
        end
        return idx;
    endfunction

    assign w_out_ready = !r_out_valid || pop;
    assign o_job_pop   = (r_state == S_IDLE) && i_job_valid;
    assign empty       = !r_out_valid;
    assign o_result    = r_out;

    // a result beat is loaded this cycle
    assign w_emit = w_out_ready &&
                    (((r_state == S_EXEC) && !((r_cmd == CMD_LIST) && r_any)) ||
                     ((r_state == S_LIST) && r_valid[r_cursor]));

    assign w_in_wide  = 64'(i_job.value);
    assign w_in_val   = w_in_wide[VALUE_WIDTH-1:0];
    assign w_val_wide = 64'(r_val);
    assign w_cur_wide = 64'(r_vals[r_cursor]);

    always_comb begin
        for (int i = 0; i < TABLE_DEPTH; i++) begin
            w_eq[i]         = (r_vals[i] == w_in_val);
            w_below_used[i] = (CW'(i) < r_used);
        end
    end

    always_comb begin
        w_ins_idx    = '0;
        w_ins_used   = r_used;
        w_ins_write  = 1'b0;
        w_ins_set    = 1'b1;
        w_ins_status = ST_STORED;
        priority if (|r_rev_vec) begin
            w_ins_idx    = first_set(r_rev_vec);
            w_ins_status = ST_REVIVED;
        end else if (|r_free_vec) begin
            w_ins_idx   = first_set(r_free_vec);
            w_ins_write = 1'b1;
        end else if (r_used < CW'(TABLE_DEPTH)) begin
            w_ins_idx   = r_used[IW-1:0];
            w_ins_used  = r_used + CW'(1);
            w_ins_write = 1'b1;
        end else begin
            w_ins_set    = 1'b0;
            w_ins_status = ST_FULL_DROP;
        end
    end

    always_comb begin
        w_del_cnt = '0;
        for (int i = 0; i < TABLE_DEPTH; i++) begin
            w_del_cnt = w_del_cnt + CW'(r_del_vec[i]);
        end
    end

    assign w_ins_idx_x = {4'd0, w_ins_idx};
    assign w_cur_idx_x = {4'd0, r_cursor};
    assign w_del_cnt_x = {5'd0, w_del_cnt};
    assign w_mem_we    = (r_state == S_EXEC) && w_out_ready && (r_cmd == CMD_INSERT)
                         && w_ins_write;

    always_ff @(posedge i_clk) begin
        if (w_mem_we) begin
            r_vals[w_ins_idx] <= r_val;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_valid     <= '0;
            r_used      <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (w_emit) begin
                r_out_valid <= 1'b1;
            end else if (pop && r_out_valid) begin
                r_out_valid <= 1'b0;
            end
            unique case (r_state)
                S_IDLE: begin
                    if (i_job_valid) begin
                        r_cmd      <= i_job.cmd;
                        r_val      <= w_in_val;
                        r_rev_vec  <= w_eq & ~r_valid & w_below_used;
                        r_free_vec <= ~r_valid & w_below_used;
                        r_del_vec  <= w_eq & r_valid;
                        r_any      <= |r_valid;
                        r_last     <= last_set(r_valid);
                        r_cursor   <= '0;
                        r_state    <= S_EXEC;
                    end
                end
                S_EXEC: begin
                    if (w_out_ready) begin
                        unique case (r_cmd)
                            CMD_INSERT: begin
                                if (w_ins_set) begin
                                    r_valid[w_ins_idx] <= 1'b1;
                                end
                                r_used            <= w_ins_used;
                                r_out.status      <= w_ins_status;
                                r_out.slot_index  <= w_ins_set ? w_ins_idx_x[3:0] : 4'd0;
                                r_out.out_value   <= w_val_wide[31:0];
                                r_out.match_count <= '0;
                                r_out.last        <= 1'b1;
                                r_state           <= S_IDLE;
                            end
                            CMD_DELETE: begin
                                r_valid           <= r_valid & ~r_del_vec;
                                r_out.status      <= ST_DELETED;
                                r_out.slot_index  <= '0;
                                r_out.out_value   <= '0;
                                r_out.match_count <= w_del_cnt_x[4:0];
                                r_out.last        <= 1'b1;
                                r_state           <= S_IDLE;
                            end
                            default: begin
                                if (r_any) begin
                                    r_state <= S_LIST;
                                end else begin
                                    r_out.status      <= ST_LIST_EMPTY;
                                    r_out.slot_index  <= '0;
                                    r_out.out_value   <= '0;
                                    r_out.match_count <= '0;
                                    r_out.last        <= 1'b1;
                                    r_state           <= S_IDLE;
                                end
                            end
                        endcase
                    end
                end
                S_LIST: begin
                    if (!r_valid[r_cursor]) begin
                        r_cursor <= r_cursor + IW'(1);
                    end else if (w_out_ready) begin
                        r_out.status      <= ST_LIST_ENTRY;
                        r_out.slot_index  <= w_cur_idx_x[3:0];
                        r_out.out_value   <= w_cur_wide[31:0];
                        r_out.match_count <= '0;
                        r_out.last        <= (r_cursor == r_last);
                        if (r_cursor == r_last) begin
                            r_state <= S_IDLE;
                        end else begin
                            r_cursor <= r_cursor + IW'(1);
                        end
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

endmodule

// ===== src/tombstone_slot_table.sv =====
// ----------------------------------------------------------------------------
// tombstone_slot_table
// ordered value slots with logical deletion: insert, delete all, list
//
//   channel   handshake         beat
//   input     push / full       i_item   (t_in_item)
//   result    empty / pop       o_result (t_out_item)
//
// insert and delete: the queued job is matched against all slots in parallel and
// the match vectors registered, then the update and result register are written.
// list: after that match step, the walk visits each slot up to and including the last valid one.
// one job in the engine at a time; a two-entry job queue and the result
// register let input and output stall independently; a waiting beat holds the engine.
// synchronous reset clears all valid marks and the used count; no sweep.
// ----------------------------------------------------------------------------
module tombstone_slot_table
    import tss_pkg::*;
#(
    parameter int TABLE_DEPTH = 16,
    parameter int VALUE_WIDTH = 32
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      push,
    output logic      full,
    input  t_in_item  i_item,
    output logic      empty,
    input  logic      pop,
    output t_out_item o_result
);

    logic w_job_valid;
    t_job w_job;
    logic w_job_pop;

    tss_front u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .push        (push),
        .full        (full),
        .i_item      (i_item),
        .o_job_valid (w_job_valid),
        .o_job       (w_job),
        .i_job_pop   (w_job_pop)
    );

    tss_back #(
        .TABLE_DEPTH (TABLE_DEPTH),
        .VALUE_WIDTH (VALUE_WIDTH)
    ) u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_job_valid (w_job_valid),
        .i_job       (w_job),
        .o_job_pop   (w_job_pop),
        .empty       (empty),
        .pop         (pop),
        .o_result    (o_result)
    );

endmodule

// ===== bench/tss_checker.sv =====
// ----------------------------------------------------------------------------
// tss_checker
// watches both queue channels of the tombstone slot table, keeps a shadow of
// the slot contents and valid marks, predicts the result beats of every
// accepted command and compares each accepted result beat field by field
// ----------------------------------------------------------------------------
module tss_checker
    import tss_pkg::*;
(
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      push,
    input  logic      full,
    input  t_in_item  i_item,
    input  logic      empty,
    input  logic      pop,
    input  t_out_item o_result,
    output int        o_errors,
    output int        o_pending
);
    timeunit 1ns;
    timeprecision 1ps;

    localparam int SLOTS = 16;

    logic signed [31:0] shadow_val [SLOTS];
    logic               shadow_live [SLOTS];
    int                 shadow_used;
    t_out_item          table_answers [$];
    int                 mismatches;

    task automatic predict_table(input t_in_item it);
        t_out_item r;
        int        hit;
        int        cnt;
        int        last_live;
        r = '0;
        r.last = 1'b1;
        hit = -1;
        cnt = 0;
        last_live = -1;
        case (it.cmd)
            CMD_INSERT: begin
                for (int i = 0; i < shadow_used; i++)
                    if (hit < 0 && !shadow_live[i] && shadow_val[i] == it.item_value)
                        hit = i;
                if (hit >= 0) begin
                    shadow_live[hit] = 1'b1;
                    r.status = ST_REVIVED;
                    r.slot_index = hit[3:0];
                end else begin
                    for (int i = 0; i < shadow_used; i++)
                        if (hit < 0 && !shadow_live[i])
                            hit = i;
                    if (hit < 0 && shadow_used < SLOTS) begin
                        hit = shadow_used;
                        shadow_used++;
                    end
                    if (hit >= 0) begin
                        shadow_val[hit] = it.item_value;
                        shadow_live[hit] = 1'b1;
                        r.status = ST_STORED;
                        r.slot_index = hit[3:0];
                    end else begin
                        r.status = ST_FULL_DROP;
                    end
                end
                r.out_value = it.item_value;
                table_answers.push_back(r);
            end
            CMD_DELETE: begin
                for (int i = 0; i < shadow_used; i++) begin
                    if (shadow_val[i] == it.item_value) begin
                        if (shadow_live[i])
                            cnt++;
                        shadow_live[i] = 1'b0;
                    end
                end
                r.status = ST_DELETED;
                r.match_count = cnt[4:0];
                table_answers.push_back(r);
            end
            CMD_LIST: begin
                for (int i = 0; i < shadow_used; i++)
                    if (shadow_live[i])
                        last_live = i;
                if (last_live < 0) begin
                    r.status = ST_LIST_EMPTY;
                    table_answers.push_back(r);
                end else begin
                    for (int i = 0; i < shadow_used; i++) begin
                        if (shadow_live[i]) begin
                            r.status = ST_LIST_ENTRY;
                            r.slot_index = i[3:0];
                            r.out_value = shadow_val[i];
                            r.last = (i == last_live);
                            table_answers.push_back(r);
                        end
                    end
                end
            end
            default: begin
            end
        endcase
    endtask

    task automatic compare_beat(input t_out_item act);
        t_out_item exp;
        if (table_answers.size() == 0) begin
            $error("result beat with nothing expected: status %0d", act.status);
            mismatches++;
        end else begin
            exp = table_answers.pop_front();
            if (act.status !== exp.status) begin
                $error("status exp %0d act %0d", exp.status, act.status);
                mismatches++;
            end
            if (act.slot_index !== exp.slot_index) begin
                $error("slot_index exp %0d act %0d", exp.slot_index, act.slot_index);
                mismatches++;
            end
            if (act.out_value !== exp.out_value) begin
                $error("out_value exp %0d act %0d", exp.out_value, act.out_value);
                mismatches++;
            end
            if (act.match_count !== exp.match_count) begin
                $error("match_count exp %0d act %0d", exp.match_count, act.match_count);
                mismatches++;
            end
            if (act.last !== exp.last) begin
                $error("last exp %0d act %0d", exp.last, act.last);
                mismatches++;
            end
        end
    endtask

    initial begin
        mismatches = 0;
        shadow_used = 0;
        o_errors = 0;
        o_pending = 0;
    end

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < SLOTS; i++) begin
                shadow_live[i] = 1'b0;
                shadow_val[i] = '0;
            end
            shadow_used = 0;
            table_answers.delete();
        end else begin
            if (pop === 1'b1 && empty === 1'b0)
                compare_beat(o_result);
            if (push === 1'b1 && full === 1'b0)
                predict_table(i_item);
        end
        o_errors <= mismatches;
        o_pending <= table_answers.size();
    end

endmodule

// ===== bench/tb.sv =====
// ----------------------------------------------------------------------------
// tb
// stimulus for the tombstone slot table: a directed opening over empty list,
// extremes, duplicates, revive, rewrite, unused command and a full table,
// then random phases with a small value pool so that inserts, deletes and
// lists keep hitting the same slots; both sides idle at random, the result
// side holds off once for long enough that the input stalls
// ----------------------------------------------------------------------------
module tb;
    import tss_pkg::*;
    timeunit 1ns;
    timeprecision 1ps;

    localparam logic [1:0] CMD_UNUSED = 2'd3;
    localparam int PHASE_BEATS = 110;

    logic      i_clk = 1'b0;
    logic      i_rst_n;
    logic      push;
    logic      full;
    t_in_item  i_item;
    logic      empty;
    logic      pop;
    t_out_item o_result;
    int        errors;
    int        pending;
    logic      push_quiet;
    logic signed [31:0] pool [8];

    tombstone_slot_table uut (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .push     (push),
        .full     (full),
        .i_item   (i_item),
        .empty    (empty),
        .pop      (pop),
        .o_result (o_result)
    );

    tss_checker u_chk (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .push      (push),
        .full      (full),
        .i_item    (i_item),
        .empty     (empty),
        .pop       (pop),
        .o_result  (o_result),
        .o_errors  (errors),
        .o_pending (pending)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    initial begin
        #3_000_000;
        $display("FAIL tombstone_slot_table");
        $finish;
    end

    task automatic send_beat(input logic [1:0] cmd, input logic signed [31:0] value);
        while (!push_quiet && $urandom_range(0, 99) < 12) begin
            push <= 1'b0;
            @(posedge i_clk);
        end
        push <= 1'b1;
        i_item <= '{cmd: cmd, item_value: value};
        do @(posedge i_clk); while (full);
    endtask

    function automatic logic signed [31:0] pick_value(input int pool_n);
        int roll;
        roll = $urandom_range(0, 99);
        if (roll < 70)
            return pool[$urandom_range(0, pool_n - 1)];
        else if (roll < 85)
            return $urandom;
        case ($urandom_range(0, 3))
            0: return 32'sh7fff_ffff;
            1: return 32'sh8000_0000;
            2: return 32'sh0000_0000;
            default: return -32'sd1;
        endcase
    endfunction

    task automatic run_phase(input int ins_pct, input int del_pct, input int list_pct,
                             input int pool_n);
        int         done;
        int         roll;
        logic [1:0] cmd;
        done = 0;
        for (int k = 0; k < 8; k++)
            pool[k] = $urandom_range(0, 1) ? 32'($urandom) : 32'($urandom_range(0, 9)) - 5;
        while (done < PHASE_BEATS) begin
            roll = $urandom_range(0, 99);
            if (roll < ins_pct)
                cmd = CMD_INSERT;
            else if (roll < ins_pct + del_pct)
                cmd = CMD_DELETE;
            else if (roll < ins_pct + del_pct + list_pct)
                cmd = CMD_LIST;
            else
                cmd = CMD_UNUSED;
            send_beat(cmd, pick_value(pool_n));
            if (cmd != CMD_UNUSED)
                done++;
        end
    endtask

    // result side: random pops, one long hold-off, one stretch with no idling
    initial begin
        int cyc;
        cyc = 0;
        pop <= 1'b0;
        @(posedge i_clk);
        while (!i_rst_n) @(posedge i_clk);
        forever begin
            @(posedge i_clk);
            cyc++;
            if (cyc >= 250 && cyc < 550)
                pop <= 1'b0;
            else if (cyc >= 800 && cyc < 1400)
                pop <= 1'b1;
            else
                pop <= ($urandom_range(0, 99) >= 12);
        end
    end

    initial begin
        i_rst_n <= 1'b0;
        push <= 1'b0;
        i_item <= '0;
        push_quiet = 1'b0;
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        send_beat(CMD_LIST, 32'sd0);
        send_beat(CMD_DELETE, 32'sd7);
        send_beat(CMD_INSERT, 32'sh7fff_ffff);
        send_beat(CMD_INSERT, 32'sh8000_0000);
        send_beat(CMD_INSERT, 32'sd0);
        send_beat(CMD_INSERT, -32'sd1);
        send_beat(CMD_INSERT, 32'sd0);
        send_beat(CMD_DELETE, 32'sd0);
        send_beat(CMD_DELETE, 32'sd0);
        send_beat(CMD_INSERT, 32'sd5);
        send_beat(CMD_INSERT, 32'sd0);
        send_beat(CMD_UNUSED, 32'sh5a5a_a5a5);
        send_beat(CMD_LIST, -32'sd1);
        for (int k = 0; k < 11; k++)
            send_beat(CMD_INSERT, 32'sd100 + k);
        send_beat(CMD_INSERT, 32'sd42);
        send_beat(CMD_LIST, 32'sd0);

        run_phase(70, 15, 12, 6);
        run_phase(45, 35, 15, 3);
        push_quiet = 1'b1;
        run_phase(85, 5, 8, 8);
        push_quiet = 1'b0;
        run_phase(55, 25, 15, 4);
        push <= 1'b0;

        @(posedge i_clk);
        while (pending != 0) @(posedge i_clk);
        repeat (40) @(posedge i_clk);
        if (errors == 0 && pending == 0)
            $display("PASS tombstone_slot_table");
        else
            $display("FAIL tombstone_slot_table");
        $finish;
    end

endmodule
